>>> rtl/core/ell_pkg.sv
// Shared constants, configuration register codes and the controller-to-datapath
// command struct for the encoder linearizer. No dependencies.
`default_nettype none

package ell_pkg;

  // Position word and calibration table geometry
  localparam int unsigned PosBits    = 18;
  localparam int unsigned TableDepth = 128;
  localparam int unsigned SegBits    = $clog2(TableDepth);
  localparam int unsigned FracBits   = PosBits - SegBits;
  localparam int unsigned OffBits    = 18;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 112;

  // Configuration port
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 18;

  localparam logic [PosBits-1:0] ZeroOffsetReset = 18'd155807;
  localparam logic [6:0]         PolePairsReset  = 7'd1;

  typedef enum logic [CfgAddrW-1:0] {
    CfgDirection  = 2'd0,
    CfgZeroOffset = 2'd1,
    CfgPolePairs  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic start;  // sample accepted: latch raw position, read two table entries
    logic load;   // table load accepted: write one entry
    logic mul;    // interpolation product
    logic corr;   // corrected count
    logic cali;   // angle after zero offset
    logic fin;    // result moves into the output register
  } ell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/ell_ctrl.sv
// Sequencer of the encoder linearizer: steps one item through the datapath and
// owns the output valid flag. Depends on ell_pkg.
`default_nettype none

module ell_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          mode_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ell_pkg::ell_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StCorr = 5'b00100,
    StCali = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, fin_fire, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_fire   = (state_q == StFin) && out_free;
  assign in_ready_o = (state_q == StIdle) || fin_fire;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = mode_i ? StFin : StMul;
      end
      StMul:  state_d = StCorr;
      StCorr: state_d = StCali;
      StCali: state_d = StFin;
      StFin: begin
        if (accept) begin
          state_d = mode_i ? StFin : StMul;
        end else if (fin_fire) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assign cmd_o.start = accept && !mode_i;
  assign cmd_o.load  = accept && mode_i;
  assign cmd_o.mul   = (state_q == StMul);
  assign cmd_o.corr  = (state_q == StCorr);
  assign cmd_o.cali  = (state_q == StCali);
  assign cmd_o.fin   = fin_fire;

  // New items enter only when idle or while the previous one leaves
  a_accept_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == StIdle || state_q == StFin))
    else $error("item accepted mid-sequence");

  a_sample_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mode_i) |=> (state_q == StMul))
    else $error("sample did not start multiply step");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> out_valid_q)
    else $error("finished result not presented");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && !out_free) |=> (state_q == StFin))
    else $error("pending result dropped");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result is blocked");

endmodule

`default_nettype wire

>>> rtl/core/ell_datapath.sv
// Datapath of the encoder linearizer: configuration registers, calibration table,
// interpolation, wrap, delta, running sum and angles. Depends on ell_pkg.
`default_nettype none

module ell_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ell_pkg::ell_cmd_t                cmd_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [ell_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  wire logic [ell_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic [ell_pkg::InDataW-1:0]      in_data_i,
  output logic      [ell_pkg::OutDataW-1:0]     out_data_o
);

  localparam int unsigned Pb = ell_pkg::PosBits;
  localparam int unsigned Sb = ell_pkg::SegBits;
  localparam int unsigned Fb = ell_pkg::FracBits;
  localparam int unsigned Ob = ell_pkg::OffBits;
  localparam int unsigned ProdW = (Ob + 1) + (Fb + 1);

  // Configuration registers
  logic          dir_q;
  logic [Pb-1:0] zero_q;
  logic [6:0]    pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      zero_q <= ell_pkg::ZeroOffsetReset;
      pp_q   <= ell_pkg::PolePairsReset;
    end else if (cfg_we_i) begin
      unique case (ell_pkg::cfg_reg_e'(cfg_addr_i))
        ell_pkg::CfgDirection:  dir_q  <= cfg_data_i[0];
        ell_pkg::CfgZeroOffset: zero_q <= cfg_data_i[Pb-1:0];
        ell_pkg::CfgPolePairs:  pp_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  logic [6:0]    tbl_index;
  logic [Ob-1:0] tbl_value;
  logic [7:0]    byte1, byte2, byte3;
  logic [Pb-1:0] word, raw;
  logic [Sb-1:0] rd_idx, rd_nxt;

  assign tbl_index = in_data_i[6:0];
  assign tbl_value = in_data_i[24:7];
  assign byte1     = in_data_i[32:25];
  assign byte2     = in_data_i[40:33];
  assign byte3     = in_data_i[48:41];

  assign word   = {byte1, byte2[7:2], byte3[7:4]};
  assign raw    = dir_q ? word : ({Pb{1'b0}} - word);
  assign rd_idx = raw[Pb-1 -: Sb];
  assign rd_nxt = rd_idx + 1'b1;

  // Calibration table, registered read of both neighbors
  logic [Ob-1:0] table_mem [ell_pkg::TableDepth];
  logic [Ob-1:0] off1_q, off2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) table_mem[tbl_index[Sb-1:0]] <= tbl_value;
    if (cmd_i.start) begin
      off1_q <= table_mem[rd_idx];
      off2_q <= table_mem[rd_nxt];
    end
  end

  logic [Pb-1:0] raw_q;
  logic          load_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) raw_q <= raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
    end else if (cmd_i.start || cmd_i.load) begin
      load_q <= cmd_i.load;
    end
  end

  // Interpolation product: (off2 - off1) * frac
  logic signed [Ob:0]      diff;
  logic signed [Fb:0]      frac;
  logic signed [ProdW-1:0] prod_d, prod_q;

  assign diff   = $signed({off2_q[Ob-1], off2_q}) - $signed({off1_q[Ob-1], off1_q});
  assign frac   = $signed({1'b0, raw_q[Fb-1:0]});
  assign prod_d = diff * frac;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= prod_d;
  end

  // Floor shift is the upper slice of the signed product; wrap is the low bits
  logic [ProdW-Fb-1:0] prod_sh;
  logic [ProdW-Fb-1:0] interp;
  logic [Pb-1:0]       count_d, count_q;

  assign prod_sh = prod_q[ProdW-1:Fb];
  assign interp  = {{(ProdW-Fb-Ob){off1_q[Ob-1]}}, off1_q} + prod_sh;
  assign count_d = raw_q - interp[Pb-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr) count_q <= count_d;
  end

  logic [Pb-1:0] mech_d, mech_q;

  assign mech_d = count_q - zero_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cali) mech_q <= mech_d;
  end

  // Result stage
  logic [Pb-1:0]   prev_q;
  logic [31:0]     sum_q, sum_d;
  logic [Pb:0]     delta;
  logic [Pb+6:0]   elec_full;

  assign delta     = {1'b0, count_q} - {1'b0, prev_q};
  assign sum_d     = sum_q + {{(32-Pb-1){delta[Pb]}}, delta};
  assign elec_full = mech_q * pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.fin && !load_q) begin
      prev_q <= count_q;
      sum_q  <= sum_d;
    end
  end

  logic [17:0] pos_q, mech_out_q, elec_q;
  logic [18:0] delta_q;
  logic [31:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (load_q) begin
        pos_q      <= '0;
        delta_q    <= '0;
        acc_q      <= '0;
        mech_out_q <= '0;
        elec_q     <= '0;
      end else begin
        pos_q      <= count_q;
        delta_q    <= delta;
        acc_q      <= sum_d;
        mech_out_q <= mech_q;
        elec_q     <= elec_full[Pb-1:0];
      end
    end
  end

  assign out_data_o = {7'd0, elec_q, mech_out_q, acc_q, delta_q, pos_q};

endmodule

`default_nettype wire

>>> rtl/core/encoder_lut_linearizer.sv
// Encoder linearizer top level: stream ports, configuration port, and the
// controller and datapath. Depends on ell_pkg, ell_ctrl and ell_datapath.
//
// Usage:
//   The slave stream carries one item per beat. tuser selects the kind: 0 is an
//   encoder sample (three raw bytes), 1 writes one calibration table entry.
//   Every item, either kind, yields exactly one beat on the master stream: the
//   corrected position, delta, running sum, mechanical and electrical angle, or
//   all zeros for a table write.
//   A sample steps through table read, interpolation multiply, correction and
//   zero offset before it reaches the last step, and no new item is taken
//   until then; table writes can be taken one per cycle while the receiver
//   keeps taking the result beats.
//   The next item is accepted in the same cycle that a result enters the output
//   register. If the receiver stalls, the result waits in the output register
//   and one more finished item waits in the last step, after which s_axis_tready
//   stays low until the master beat is taken.
//   Reset clears the sequencer, the output valid, the previous position and the
//   running sum, and loads the registers with their defaults (direction mirrored,
//   zero offset 155807, one pole pair). The table is not cleared; write every
//   entry before sampling. The configuration port is always ready; write it only
//   while no item is in flight.
`default_nettype none

module encoder_lut_linearizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: table_index[6:0], table_value[24:7], first_byte[32:25],
  //        second_byte[40:33], third_byte[48:41], zero pad [55:49]
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ell_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: mode[0]
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: position[17:0], position_delta[36:18], accumulated[68:37],
  //        mech_angle[86:69], electrical_angle[104:87], zero pad [111:105]
  output logic      [ell_pkg::OutDataW-1:0]  m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ell_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [ell_pkg::CfgDataW-1:0]  cfg_data_i
);

  ell_pkg::ell_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ell_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ell_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> test/encoder_lut_linearizer_tb.sv
// Self-checking testbench for encoder_lut_linearizer: table loads, samples and register
// settings on the stream and configuration ports, each result checked against a predictor.
// Depends on ell_pkg and the encoder_lut_linearizer RTL.
`default_nettype none

module encoder_lut_linearizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeSample = 1'b0;
  localparam logic ModeLoad   = 1'b1;

  localparam int unsigned RandomItems  = 1600;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned MaxPrints    = 40;

  typedef struct packed {
    logic [17:0] pos;
    logic [18:0] delta;
    logic [31:0] acc;
    logic [17:0] mech;
    logic [17:0] elec;
  } lin_result_t;

  // Predicts the linearized position and angles, and holds the results still owed.
  class linearizer_sb;
    logic signed [ell_pkg::OffBits-1:0] lut [ell_pkg::TableDepth];
    logic [17:0] prev_pos;
    logic [31:0] pos_sum;
    logic        dir_fwd;
    logic [17:0] zero_off;
    logic [6:0]  pole_pairs;
    lin_result_t owed_q[$];
    int unsigned errors;

    function new();
      prev_pos   = '0;
      pos_sum    = '0;
      dir_fwd    = 1'b0;
      zero_off   = ell_pkg::ZeroOffsetReset;
      pole_pairs = ell_pkg::PolePairsReset;
      errors     = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void write_reg(logic [ell_pkg::CfgAddrW-1:0] addr,
                            logic [ell_pkg::CfgDataW-1:0] data);
      case (addr)
        ell_pkg::CfgDirection:  dir_fwd    = data[0];
        ell_pkg::CfgZeroOffset: zero_off   = data[17:0];
        ell_pkg::CfgPolePairs:  pole_pairs = data[6:0];
        default: ;
      endcase
    endfunction

    function void predict_position(logic mode, logic [ell_pkg::InDataW-1:0] d);
      lin_result_t r;
      logic [17:0] word;
      logic [17:0] raw;
      logic [6:0]  seg;
      logic [6:0]  nseg;
      longint      lo;
      longint      hi;
      longint      frac;
      longint      rawl;
      longint      interp;
      longint      mechl;
      longint      ppl;
      longint      prod;
      logic [17:0] cnt;
      logic [18:0] dlt;
      logic [17:0] mech;
      r = '0;
      if (mode == ModeLoad) begin
        lut[d[6:0]] = d[24:7];
        owed_q.push_back(r);
        return;
      end
      word = {d[32:25], d[40:35], d[48:45]};
      raw  = dir_fwd ? word : 18'(18'd0 - word);
      seg  = raw[17:11];
      nseg = seg + 7'd1;
      lo   = lut[seg];
      hi   = lut[nseg];
      frac = raw[10:0];
      rawl = raw;
      // floor rounding: arithmetic shift of the signed product
      interp = lo + (((hi - lo) * frac) >>> 11);
      cnt  = 18'(rawl - interp);
      dlt  = 19'({1'b0, cnt} - {1'b0, prev_pos});
      prev_pos = cnt;
      pos_sum  = pos_sum + {{13{dlt[18]}}, dlt};
      mech  = 18'(cnt - zero_off);
      mechl = mech;
      ppl   = pole_pairs;
      prod  = mechl * ppl;
      r.pos   = cnt;
      r.delta = dlt;
      r.acc   = pos_sum;
      r.mech  = mech;
      r.elec  = prod[17:0];
      owed_q.push_back(r);
    endfunction

    function void check_beat(logic [ell_pkg::OutDataW-1:0] d);
      lin_result_t w;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat with nothing expected, data %h", d));
        return;
      end
      w = owed_q.pop_front();
      if (d[17:0] !== w.pos)
        report($sformatf("position %h, expected %h", d[17:0], w.pos));
      if (d[36:18] !== w.delta)
        report($sformatf("position_delta %h, expected %h", d[36:18], w.delta));
      if (d[68:37] !== w.acc)
        report($sformatf("accumulated %h, expected %h", d[68:37], w.acc));
      if (d[86:69] !== w.mech)
        report($sformatf("mech_angle %h, expected %h", d[86:69], w.mech));
      if (d[104:87] !== w.elec)
        report($sformatf("electrical_angle %h, expected %h", d[104:87], w.elec));
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [ell_pkg::InDataW-1:0]  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [ell_pkg::OutDataW-1:0] m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ell_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [ell_pkg::CfgDataW-1:0] cfg_data = '0;

  // beats seen at the falling edge, taken at the next rising edge
  logic in_beat  = 1'b0;
  logic out_beat = 1'b0;
  logic cfg_beat = 1'b0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;

  linearizer_sb sb = new();

  encoder_lut_linearizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    in_beat  = rst_ni && s_tvalid && s_tready;
    out_beat = rst_ni && m_tvalid && m_tready;
    cfg_beat = rst_ni && cfg_valid && cfg_ready;
    if (cfg_beat) sb.write_reg(cfg_addr, cfg_data);
    if (in_beat) sb.predict_position(s_tuser, s_tdata);
    if (out_beat) sb.check_beat(m_tdata);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (in_beat || out_beat || cfg_beat) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_item(input logic mode, input logic [ell_pkg::InDataW-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= mode;
    @(posedge clk_i);
    while (!in_beat) @(posedge clk_i);
  endtask

  task automatic push_load(input logic [6:0] idx, input logic [17:0] value);
    push_item(ModeLoad, {7'd0, 24'($urandom), value, idx});
  endtask

  task automatic push_bytes(input logic [23:0] bytes);
    push_item(ModeSample, {7'd0, bytes, 18'($urandom), 7'($urandom)});
  endtask

  // Build the three bytes from an 18-bit position; discarded low bits get noise.
  task automatic push_raw(input logic [17:0] raw);
    logic [7:0] b2;
    logic [7:0] b3;
    b2 = {raw[9:4], 2'($urandom)};
    b3 = {raw[3:0], 4'($urandom)};
    push_bytes({b3, b2, raw[17:10]});
  endtask

  task automatic write_cfg(input ell_pkg::cfg_reg_e addr,
                           input logic [ell_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_beat) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 20) push_load(7'($urandom), 18'($urandom));
      else push_bytes(24'($urandom));
    end
  endtask

  task automatic random_config();
    logic [17:0] zoff;
    case ($urandom_range(3))
      0: zoff = 18'd0;
      1: zoff = 18'h3FFFF;
      default: zoff = 18'($urandom);
    endcase
    write_cfg(ell_pkg::CfgDirection, {17'($urandom), 1'($urandom)});
    write_cfg(ell_pkg::CfgZeroOffset, zoff);
    write_cfg(ell_pkg::CfgPolePairs, {11'($urandom), 7'($urandom_range(1, 64))});
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole table before the first sample reads it
    for (int i = 0; i < ell_pkg::TableDepth; i++) push_load(7'(i), 18'($urandom));
    push_load(7'd0, 18'h20000);
    push_load(7'd127, 18'h1FFFF);

    // reset settings: mirrored direction, default zero offset, one pole pair
    push_raw(18'd0);
    push_raw(18'h3FFFF);
    push_raw(18'd1);
    push_raw({7'd64, 11'h7FF});
    wait_idle();

    write_cfg(ell_pkg::CfgDirection, {17'($urandom), 1'b1});
    write_cfg(ell_pkg::CfgZeroOffset, 18'd0);
    write_cfg(ell_pkg::CfgPolePairs, {11'($urandom), 7'd64});
    push_raw(18'd0);
    push_raw(18'h3FFFF);
    push_raw({7'd127, 11'h7FF});
    push_raw({7'd127, 11'd0});
    push_load(7'd3, 18'd0);
    push_load(7'd4, 18'd0);
    push_raw({7'd3, 11'h123});
    // steepest neighbour step: largest positive entry next to most negative
    push_load(7'd5, 18'h1FFFF);
    push_load(7'd6, 18'h20000);
    push_raw({7'd5, 11'h7FF});
    push_raw({7'd6, 11'd0});
    wait_idle();

    write_cfg(ell_pkg::CfgZeroOffset, 18'h3FFFF);
    write_cfg(ell_pkg::CfgPolePairs, 18'd0);
    push_raw(18'd0);
    push_raw(18'h3FFFF);
    push_bytes(24'($urandom));
    wait_idle();

    write_cfg(ell_pkg::CfgPolePairs, {11'($urandom), 7'd127});
    write_cfg(ell_pkg::CfgDirection, {17'($urandom), 1'b0});
    push_raw({7'd5, 11'h7FF});
    push_raw(18'h3FFFF);
    wait_idle();

    tx_idle_pct = 10;
    rx_idle_pct = 63;
    random_config();
    random_phase(RandomItems / 3);
    wait_idle();

    tx_idle_pct = 63;
    rx_idle_pct = 10;
    random_config();
    random_phase(RandomItems / 3);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_config();
    // hold the output while input keeps coming, so the block backs up
    rx_hold_req = 1'b1;
    random_phase(RandomItems / 3);
    wait_idle();

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/ell_pkg.sv
rtl/core/ell_ctrl.sv
rtl/core/ell_datapath.sv
rtl/core/encoder_lut_linearizer.sv
test/encoder_lut_linearizer_tb.sv
